### hw/rtl/sfp_pkg.sv
package sfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 8;
  // Frame sum of four bytes never exceeds 4 * 255.
  localparam int unsigned SumW    = ByteW + 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgIdxStartMarker = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxEndMarker   = CfgIdxW'(1);

  // Register reset values.
  localparam logic [ByteW-1:0] StartMarkerRst = 8'hFF;
  localparam logic [ByteW-1:0] EndMarkerRst   = 8'hFE;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] end_marker;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] frame_id;
    logic [ByteW-1:0] frame_message;
  } res_t;

  typedef struct packed {
    logic in_valid;  // input register holds a byte
    logic at_check;  // parser waits for the low checksum byte
  } stat_t;

endpackage

### hw/rtl/sfp_if.sv
interface sfp_rx_if;
  logic                     valid;
  logic                     ready;
  logic [sfp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_frame_if;
  logic                     valid;
  logic                     ready;
  logic [sfp_pkg::ByteW-1:0] frame_id;
  logic [sfp_pkg::ByteW-1:0] frame_message;

  modport source (output valid, output frame_id, output frame_message, input ready);
  modport sink   (input valid, input frame_id, input frame_message, output ready);
endinterface

interface sfp_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sfp_pkg::CfgIdxW-1:0] index;
  logic [sfp_pkg::ByteW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/sfp_cfg_regs.sv
module sfp_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  sfp_cfg_if.sink       cfg_i,
  output sfp_pkg::cfg_t cfg_o
);
  import sfp_pkg::*;

  logic [ByteW-1:0] start_marker_q;
  logic [ByteW-1:0] end_marker_q;

  assign cfg_i.ready = 1'b1;

  // Ignore writes to indexes past the register list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= StartMarkerRst;
      end_marker_q   <= EndMarkerRst;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgIdxStartMarker) begin
        start_marker_q <= cfg_i.data;
      end
      if (cfg_i.index == CfgIdxEndMarker) begin
        end_marker_q <= cfg_i.data;
      end
    end
  end

  assign cfg_o.start_marker = start_marker_q;
  assign cfg_o.end_marker   = end_marker_q;

endmodule

### hw/rtl/sfp_parser.sv
module sfp_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  sfp_rx_if.sink         rx_i,
  input  sfp_pkg::cfg_t  cfg_i,
  input  logic           out_room_i,
  output sfp_pkg::res_t  res_o,
  output sfp_pkg::stat_t stat_o
);
  import sfp_pkg::*;

  localparam logic [2:0] PhHunt  = 3'd0;
  localparam logic [2:0] PhStart = 3'd1;
  localparam logic [2:0] PhId    = 3'd2;
  localparam logic [2:0] PhMsg   = 3'd3;
  localparam logic [2:0] PhEnd   = 3'd4;
  localparam logic [2:0] PhSumHi = 3'd5;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic [2:0]       phase_q, phase_d;
  logic [ByteW-1:0] id_q, id_d;
  logic [ByteW-1:0] msg_q, msg_d;
  logic [ByteW-1:0] sum_hi_q, sum_hi_d;
  logic             advance;
  logic             sum_ok;
  logic             emit;
  logic [SumW-1:0]  frame_sum;

  assign advance     = in_valid_q && out_room_i;
  assign rx_i.ready  = !in_valid_q || out_room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  assign frame_sum = SumW'(cfg_i.start_marker) + SumW'(id_q)
                   + SumW'(msg_q) + SumW'(cfg_i.end_marker);
  assign sum_ok = ({sum_hi_q, in_byte_q} == (2*ByteW)'(frame_sum));

  always_comb begin
    phase_d  = phase_q;
    id_d     = id_q;
    msg_d    = msg_q;
    sum_hi_d = sum_hi_q;
    emit     = 1'b0;
    case (phase_q)
      PhHunt: begin
        if (in_byte_q == cfg_i.start_marker) phase_d = PhStart;
      end
      PhStart: begin
        id_d    = in_byte_q;
        phase_d = PhId;
      end
      PhId: begin
        msg_d   = in_byte_q;
        phase_d = PhMsg;
      end
      PhMsg: begin
        phase_d = (in_byte_q == cfg_i.end_marker) ? PhEnd : PhHunt;
      end
      PhEnd: begin
        sum_hi_d = in_byte_q;
        phase_d  = PhSumHi;
      end
      PhSumHi: begin
        phase_d = PhHunt;
        emit    = sum_ok;
      end
      default: begin
        // Unused codes act as hunting.
        phase_d = (in_byte_q == cfg_i.start_marker) ? PhStart : PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      id_q     <= '0;
      msg_q    <= '0;
      sum_hi_q <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      id_q     <= id_d;
      msg_q    <= msg_d;
      sum_hi_q <= sum_hi_d;
    end
  end

  assign res_o.valid         = advance && emit;
  assign res_o.frame_id      = id_q;
  assign res_o.frame_message = msg_q;

  assign stat_o.in_valid = in_valid_q;
  assign stat_o.at_check = (phase_q == PhSumHi);

endmodule

### hw/rtl/sfp_out_reg.sv
module sfp_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfp_pkg::res_t res_i,
  output logic          out_room_o,
  sfp_frame_if.source   frame_o
);
  import sfp_pkg::*;

  logic             valid_q;
  logic [ByteW-1:0] id_q;
  logic [ByteW-1:0] msg_q;

  // Room when empty or when the held result leaves this cycle.
  assign out_room_o = !valid_q || frame_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_room_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_room_o && res_i.valid) begin
      id_q  <= res_i.frame_id;
      msg_q <= res_i.frame_message;
    end
  end

  assign frame_o.valid         = valid_q;
  assign frame_o.frame_id      = id_q;
  assign frame_o.frame_message = msg_q;

endmodule

### hw/rtl/serial_frame_parser_sum_check_core.sv
// Channel   Dir  Payload                          Transfer
// rx_i      in   rx_byte[7:0]                     valid & ready
// frame_o   out  frame_id[7:0], frame_message[7:0] valid & ready
// cfg_i     in   index[7:0], data[7:0]            valid & ready (ready tied high)
//
// One byte per cycle while the result register has room: a byte lands in
// the input register, the parser decides the next phase and any result
// from it combinationally, the result register holds it. Result valid
// rises when the result of the low checksum byte enters the result register.
// Reset clears phase, held bytes and markers (start 0xFF, end 0xFE).
// A result waiting in the result register holds the parser; the input takes
// one more byte into the input register, then stalls until the result leaves.
module serial_frame_parser_sum_check_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfp_rx_if.sink      rx_i,
  sfp_frame_if.source frame_o,
  sfp_cfg_if.sink     cfg_i
);
  import sfp_pkg::*;

  cfg_t  cfg;
  res_t  res;
  stat_t stat;
  logic  out_room;

  // Marker registers.
  sfp_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Input register and frame phase tracking; checks the sum on the last byte.
  sfp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_i),
    .cfg_i      (cfg),
    .out_room_i (out_room),
    .res_o      (res),
    .stat_o     (stat)
  );

  // Result register; advance the parser only when it has room.
  sfp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .out_room_o (out_room),
    .frame_o    (frame_o)
  );

  // A result comes only from a held byte at the checksum phase.
  a_res_at_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (stat.in_valid && stat.at_check))
    else $error("result raised outside the checksum phase");

  // A held byte is never dropped while the result register is blocked.
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.in_valid && !out_room) |=> stat.in_valid)
    else $error("input byte lost during output stall");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_o.valid && !frame_o.ready) |=> (frame_o.valid &&
      $stable(frame_o.frame_id) && $stable(frame_o.frame_message)))
    else $error("pending result overwritten");

endmodule

### tb/tb.sv
module tb;
  import sfp_pkg::*;

  // Run length and stall shaping.
  localparam int unsigned ByteTarget  = 1500;
  localparam int unsigned FrameTarget = 48;
  localparam int unsigned SettleCyc   = 4;     // covers the byte-to-result latency with margin
  localparam int unsigned HoldCyc     = 300;   // long receiver hold-off
  localparam int unsigned IdleLimit   = 5000;  // cycles with no transfer before giving up

  // Register indexes past the last real one; writes to them must be dropped.
  localparam logic [CfgIdxW-1:0] CfgIdxBeyond = CfgIdxEndMarker + 1'b1;
  localparam logic [CfgIdxW-1:0] CfgIdxTop    = '1;

  typedef enum logic [2:0] {
    SeekStart, GotStart, GotId, GotMsg, GotEnd, GotSumHi
  } parse_phase_e;

  // How a row of the directed table is handled:
  //   RowQuiet   - byte that must produce no frame
  //   RowFrame   - byte that must produce the frame typed in the row
  //   RowPredict - byte whose outcome comes from the parser model
  //   RowReg     - register write (a = index, b = data)
  typedef enum logic [1:0] {RowQuiet, RowFrame, RowPredict, RowReg} row_kind_e;

  typedef struct packed {
    logic [ByteW-1:0] id;
    logic [ByteW-1:0] msg;
  } frame_t;

  typedef struct packed {
    row_kind_e        kind;
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] c;
  } dir_row_t;

  // Reset markers are 0xFF (start) and 0xFE (end) until the start marker is moved.
  localparam dir_row_t DirRows [32] = '{
    '{RowQuiet,   8'h00, 8'h00, 8'h00},  // noise while hunting
    // all-zero payload: sum 0x01FD
    '{RowQuiet,   8'hFF, 8'h00, 8'h00},
    '{RowQuiet,   8'h00, 8'h00, 8'h00},
    '{RowQuiet,   8'h00, 8'h00, 8'h00},
    '{RowQuiet,   8'hFE, 8'h00, 8'h00},
    '{RowQuiet,   8'h01, 8'h00, 8'h00},
    '{RowFrame,   8'hFD, 8'h00, 8'h00},
    // all-ones payload, start marker value used as data: sum 0x03FB
    '{RowQuiet,   8'hFF, 8'h00, 8'h00},
    '{RowQuiet,   8'hFF, 8'h00, 8'h00},
    '{RowQuiet,   8'hFF, 8'h00, 8'h00},
    '{RowQuiet,   8'hFE, 8'h00, 8'h00},
    '{RowQuiet,   8'h03, 8'h00, 8'h00},
    '{RowFrame,   8'hFB, 8'hFF, 8'hFF},
    // wrong end marker: back to hunting
    '{RowQuiet,   8'hFF, 8'h00, 8'h00},
    '{RowQuiet,   8'h12, 8'h00, 8'h00},
    '{RowQuiet,   8'h34, 8'h00, 8'h00},
    '{RowQuiet,   8'h00, 8'h00, 8'h00},
    // good framing, checksum wrong
    '{RowQuiet,   8'hFF, 8'h00, 8'h00},
    '{RowQuiet,   8'h12, 8'h00, 8'h00},
    '{RowQuiet,   8'h34, 8'h00, 8'h00},
    '{RowQuiet,   8'hFE, 8'h00, 8'h00},
    '{RowQuiet,   8'h00, 8'h00, 8'h00},
    '{RowQuiet,   8'h00, 8'h00, 8'h00},
    // move the start marker mid-frame; the sum must use the new value
    '{RowQuiet,   8'hFF, 8'h00, 8'h00},
    '{RowQuiet,   8'h5A, 8'h00, 8'h00},
    '{RowQuiet,   8'hA5, 8'h00, 8'h00},
    '{RowQuiet,   8'hFE, 8'h00, 8'h00},
    '{RowReg,     CfgIdxStartMarker, 8'h10, 8'h00},
    '{RowQuiet,   8'h02, 8'h00, 8'h00},
    '{RowPredict, 8'h0D, 8'h00, 8'h00},
    // writes past the register map are dropped
    '{RowReg,     CfgIdxBeyond, 8'h77, 8'h00},
    '{RowReg,     CfgIdxTop,    8'h00, 8'h00}
  };

  logic clk;
  logic rst_n;

  sfp_rx_if    rx_ch ();
  sfp_frame_if frame_ch ();
  sfp_cfg_if   cfg_ch ();

  serial_frame_parser_sum_check_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .rx_i    (rx_ch),
    .frame_o (frame_ch),
    .cfg_i   (cfg_ch)
  );

  // Parser model state, mirrored from the block.
  parse_phase_e     phase    = SeekStart;
  logic [ByteW-1:0] start_mk = StartMarkerRst;
  logic [ByteW-1:0] end_mk   = EndMarkerRst;
  logic [ByteW-1:0] held_id  = '0;
  logic [ByteW-1:0] held_msg = '0;
  logic [ByteW-1:0] sum_hi   = '0;

  frame_t      pending_frames [$];   // frames still owed by the block, oldest first
  int unsigned mismatch_cnt = 0;
  int unsigned frames_seen  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned idle_cycles  = 0;
  bit          no_gaps      = 1'b0;  // burst mode: neither side idles
  bit          hold_req     = 1'b0;  // ask the receiver for a long hold-off

  // Free-running clock, period 8.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the parser model by one byte; return 1 when a frame is due.
  function bit parse_byte(input logic [ByteW-1:0] b, output frame_t f);
    logic [15:0] want;
    f = '0;
    parse_byte = 1'b0;
    case (phase)
      GotStart: begin
        held_id = b;
        phase   = GotId;
      end
      GotId: begin
        held_msg = b;
        phase    = GotMsg;
      end
      GotMsg: begin
        phase = (b == end_mk) ? GotEnd : SeekStart;
      end
      GotEnd: begin
        sum_hi = b;
        phase  = GotSumHi;
      end
      GotSumHi: begin
        // Always return to hunting; emit only on a matching sum.
        phase = SeekStart;
        want  = 16'(start_mk) + 16'(held_id) + 16'(held_msg) + 16'(end_mk);
        if ({sum_hi, b} == want) begin
          f = '{id: held_id, msg: held_msg};
          parse_byte = 1'b1;
        end
      end
      default: begin
        // Hunting: only the start marker opens a frame.
        if (b == start_mk) phase = GotStart;
      end
    endcase
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("ERROR: %s", what);
  endtask

  // Offer one byte, hold it until the transfer, then log what it should cause.
  // Leave valid high when no gap follows so back-to-back bytes stream.
  task automatic send_byte(input logic [ByteW-1:0] b, input row_kind_e kind,
                           input frame_t typed);
    frame_t      got;
    bit          hit;
    int unsigned gap;
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
    hit = parse_byte(b, got);
    case (kind)
      RowFrame:   pending_frames.push_back(typed);
      RowPredict: if (hit) pending_frames.push_back(got);
      default: ;
    endcase
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write a register with the block idle: drain owed frames, let the last byte
  // settle through the pipeline, then do the transfer.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] data);
    rx_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CfgIdxStartMarker) start_mk = data;
    else if (idx == CfgIdxEndMarker) end_mk = data;
  endtask

  // Result side: random back-pressure, plus one long hold-off on request so
  // the block fills up and stalls its input.
  initial begin
    int unsigned stall;
    int unsigned held;
    frame_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        frame_ch.ready <= 1'b0;
        for (held = 0; held < HoldCyc; held++) @(posedge clk);
        hold_req = 1'b0;
      end else if (no_gaps || $urandom_range(0, 99) < 60) begin
        frame_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        frame_ch.ready <= 1'b0;
        stall = pick_gap() + 1;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Check every frame transfer against the oldest owed frame.
  always @(posedge clk) begin
    frame_t want;
    if (frame_ch.valid && frame_ch.ready) begin
      frames_seen++;
      if (pending_frames.size() == 0) begin
        note_mismatch($sformatf("unexpected frame id %02h msg %02h",
                                frame_ch.frame_id, frame_ch.frame_message));
      end else begin
        want = pending_frames.pop_front();
        if (frame_ch.frame_id !== want.id || frame_ch.frame_message !== want.msg)
          note_mismatch($sformatf("frame id/msg expected %02h/%02h got %02h/%02h",
                                  want.id, want.msg,
                                  frame_ch.frame_id, frame_ch.frame_message));
      end
    end
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk) begin
    if (!rst_n || (rx_ch.valid && rx_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Main stimulus.
  initial begin
    int unsigned      phase_no;
    int unsigned      target;
    int unsigned      r;
    int unsigned      cut;
    logic [ByteW-1:0] burst [$];
    logic [ByteW-1:0] id;
    logic [ByteW-1:0] msg;
    logic [ByteW-1:0] new_start;
    logic [ByteW-1:0] new_end;
    logic [15:0]      sum;

    rst_n         = 1'b0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, bad end marker, bad sum, mid-frame register move.
    foreach (DirRows[i]) begin
      if (DirRows[i].kind == RowReg)
        write_reg(DirRows[i].a, DirRows[i].b);
      else
        send_byte(DirRows[i].a, DirRows[i].kind, '{id: DirRows[i].b, msg: DirRows[i].c});
    end

    // Random phases: new markers, then a burst of mostly well-formed frames.
    phase_no = 1;
    while (bytes_sent < ByteTarget || frames_seen < FrameTarget) begin
      case (phase_no % 5)
        0: begin new_start = 8'($urandom_range(0, 255)); new_end = 8'($urandom_range(0, 255)); end
        1: begin new_start = 8'h00; new_end = 8'h00; end
        2: begin new_start = 8'hFF; new_end = 8'hFF; end
        3: begin new_start = 8'h00; new_end = 8'hFF; end
        default: begin new_start = 8'($urandom_range(0, 255)); new_end = new_start; end
      endcase
      // Phases often end mid-frame, so some of these writes land mid-frame too.
      if (phase_no % 5 < 3 || $urandom_range(0, 3) != 0) write_reg(CfgIdxStartMarker, new_start);
      if (phase_no % 5 < 3 || $urandom_range(0, 3) != 0) write_reg(CfgIdxEndMarker, new_end);
      if ($urandom_range(0, 3) == 0)
        write_reg(CfgIdxW'($urandom_range(CfgIdxBeyond, CfgIdxTop)),
                  8'($urandom_range(0, 255)));

      // Stream hard while the receiver holds off once; otherwise sometimes burst.
      no_gaps = (phase_no == 2) || ($urandom_range(0, 3) == 0);
      if (phase_no == 2) hold_req = 1'b1;

      burst.delete();
      target = $urandom_range(20, 200);
      while (burst.size() < target) begin
        r   = $urandom_range(0, 99);
        id  = ($urandom_range(0, 7) == 0) ? start_mk : 8'($urandom_range(0, 255));
        msg = ($urandom_range(0, 7) == 0) ? start_mk : 8'($urandom_range(0, 255));
        sum = 16'(start_mk) + 16'(id) + 16'(msg) + 16'(end_mk);
        if (r < 70) begin
          burst.push_back(start_mk); burst.push_back(id); burst.push_back(msg);
          burst.push_back(end_mk); burst.push_back(sum[15:8]); burst.push_back(sum[7:0]);
        end else if (r < 80) begin
          // Flip at least one checksum bit.
          sum ^= 16'($urandom_range(1, 65535));
          burst.push_back(start_mk); burst.push_back(id); burst.push_back(msg);
          burst.push_back(end_mk); burst.push_back(sum[15:8]); burst.push_back(sum[7:0]);
        end else if (r < 88) begin
          burst.push_back(start_mk); burst.push_back(id); burst.push_back(msg);
          burst.push_back(end_mk ^ 8'($urandom_range(1, 255)));
        end else begin
          repeat ($urandom_range(1, 6)) burst.push_back(8'($urandom_range(0, 255)));
        end
      end
      // Sometimes drop the tail so the next phase opens mid-frame.
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, 5);
        repeat (cut) void'(burst.pop_back());
      end

      foreach (burst[i]) send_byte(burst[i], RowPredict, '0);
      phase_no++;
    end

    // Drain: wait for every owed frame, then give stray output time to show.
    rx_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (4 * SettleCyc) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
